### hdl/zmtd_pkg.sv
// Package for the packed text word decoder: field widths, result kind codes,
// register indexes and the built-in alphabet tables.
// No dependencies.
package zmtd_pkg;

    // Field widths
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 17;
    localparam int VER_W   = 4;
    localparam int BASE_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABBR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEST = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABBR_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE  = 2'd2;

    // Register reset values
    localparam logic [VER_W-1:0]  VERSION_RST = 4'd3;
    localparam logic [BASE_W-1:0] ABBR_BASE_RST = 16'd0;
    localparam logic [CHAR_W-1:0] NEWLINE_RST = 8'd10;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

    // Punctuation row, later versions
    localparam logic [CHAR_W-1:0] ROW2 [26] = '{
        8'h00, 8'h0d, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23, 8'h27, 8'h22,
        8'h2f, 8'h5c, 8'h2d, 8'h3a, 8'h28, 8'h29
    };

    // Punctuation row, version 1
    localparam logic [CHAR_W-1:0] ROW3 [26] = '{
        8'h20, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23, 8'h27, 8'h22, 8'h2f,
        8'h5c, 8'h3c, 8'h2d, 8'h3a, 8'h28, 8'h29
    };

    // Alphabet lookup: row 0 lower case, row 1 upper case, row 2 punctuation
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [1:0]        row,
        input logic [CODE_W-1:0] col,
        input logic              v1
    );
        logic [CHAR_W-1:0] ch;
        case (row)
            2'd0:    ch = 8'h61 + {3'd0, col};
            2'd1:    ch = 8'h41 + {3'd0, col};
            default: ch = v1 ? ROW3[col] : ROW2[col];
        endcase
        return ch;
    endfunction

endpackage

### hdl/zmtd_ifs.sv
// Channel interfaces of the text word decoder: input words, results and
// configuration writes. Depends on zmtd_pkg.
interface zmtd_in_if import zmtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              restart;
    logic              in_abbreviation;

    modport source (output valid, word, restart, in_abbreviation, input ready);
    modport sink   (input valid, word, restart, in_abbreviation, output ready);
endinterface

interface zmtd_out_if import zmtd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, kind, value, last, input ready);
    modport sink   (input valid, kind, value, last, output ready);
endinterface

interface zmtd_cfg_if import zmtd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/zmachine_text_word_decoder.sv
// Top level of the packed text word decoder.
// Depends on zmtd_pkg and the interfaces in zmtd_ifs.sv.

// A word beat is registered, then decoded combinationally into up to three
// results (three 5-bit codes, each seeing the shift state the previous one
// leaves) that load a three-entry result buffer; the buffer hands out one
// result per cycle while the result channel is ready. The first result comes
// out of the result buffer, which follows the input register. Words with at
// most one result are taken one per cycle while the result channel is ready;
// a new word loads the buffer only when it is empty or its last result is
// being taken. Words with no result produce no beat on the result channel.
// Configuration writes are always accepted and must only be issued while
// the decoder is idle.
module zmachine_text_word_decoder import zmtd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    zmtd_in_if.sink      words,
    zmtd_out_if.source   results,
    zmtd_cfg_if.sink     cfg
);

    // Per-bank decode state
    typedef struct packed {
        logic [1:0] temp_shift;
        logic [1:0] locked;
        logic [1:0] esc_cnt;
        logic [4:0] esc_high;
        logic [1:0] pend;
    } bank_t;

    // Outcome of decoding one code
    typedef struct packed {
        bank_t              st;
        logic               v;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } step_t;

    // Configuration registers
    logic [VER_W-1:0]  version_reg;
    logic [BASE_W-1:0] abbr_base_reg;
    logic [CHAR_W-1:0] newline_reg;

    // Input register
    logic              inv_reg;
    logic [WORD_W-1:0] word_reg;
    logic              restart_reg;
    logic              abbr_reg;

    // Bank state
    bank_t bank_reg  [2];
    bank_t bank_next [2];

    // Result buffer, entry 0 is the head
    logic [KIND_W-1:0]  res_kind_reg   [3];
    logic [VALUE_W-1:0] res_value_reg  [3];
    logic               res_last_reg   [3];
    logic [KIND_W-1:0]  res_kind_next  [3];
    logic [VALUE_W-1:0] res_value_next [3];
    logic               res_last_next  [3];
    logic [1:0]         res_cnt_reg;
    logic [1:0]         res_cnt_next;

    logic  pop;
    logic  load_ok;
    logic  load;
    bank_t s0;
    step_t d0;
    step_t d1;
    step_t d2;
    step_t p0;
    step_t p1;
    logic [1:0] n_res;

    // Decode one 5-bit code against a bank state
    function automatic step_t decode_code(
        input bank_t             s,
        input logic [CODE_W-1:0] c,
        input logic              b
    );
        step_t             r;
        logic              old;
        logic [2:0]        sum;
        logic [1:0]        ts;
        logic [1:0]        row;
        logic [CHAR_W-1:0] ch;
        r       = '0;
        r.st    = s;
        r.kind  = KIND_CHAR;
        old     = (version_reg <= 4'd2);
        ch      = '0;
        sum     = '0;
        ts      = s.temp_shift;
        row     = '0;
        if (s.esc_cnt != 2'd0)
        begin
            // escape pair: high half, then low half emits
            if (s.esc_cnt == 2'd2)
                r.st.esc_high = c;
            else
            begin
                r.v = 1'b1;
                ch  = {s.esc_high[2:0], c};
            end
            r.st.esc_cnt = s.esc_cnt - 2'd1;
        end
        else if (s.pend != 2'd0)
        begin
            // abbreviation entry address
            r.v       = 1'b1;
            r.kind    = KIND_ABBR;
            r.value   = {1'b0, abbr_base_reg} + {9'd0, s.pend - 2'd1, 6'd0}
                        + {11'd0, c, 1'b0};
            r.st.pend = 2'd0;
        end
        else
        begin
            case (c)
                5'd0:
                begin
                    r.v = 1'b1;
                    ch  = CH_SPACE;
                    r.st.temp_shift = 2'd0;
                end
                5'd1, 5'd2, 5'd3:
                begin
                    if (c == 5'd1 && version_reg == 4'd1)
                    begin
                        r.v = 1'b1;
                        ch  = CH_LF;
                        r.st.temp_shift = 2'd0;
                    end
                    else if (version_reg > 4'd2 || (version_reg == 4'd2 && c == 5'd1))
                    begin
                        if (b)
                        begin
                            r.v    = 1'b1;
                            r.kind = KIND_NEST;
                        end
                        else
                            r.st.pend = c[1:0];
                        r.st.temp_shift = 2'd0;
                    end
                    else
                        r.st.temp_shift = c[1:0] - 2'd1;
                end
                5'd4, 5'd5:
                begin
                    if (old)
                    begin
                        // lock advances by one or two rows, modulo three
                        sum = {1'b0, s.locked} + ((c == 5'd4) ? 3'd1 : 3'd2);
                        r.st.locked     = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
                        r.st.temp_shift = 2'd0;
                    end
                    else
                        r.st.temp_shift = (c == 5'd4) ? 2'd1 : 2'd2;
                end
                default:
                begin
                    if (old)
                    begin
                        sum = {1'b0, s.locked} + {1'b0, ts};
                        ts  = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
                    end
                    if (c == 5'd6 && ts == 2'd2)
                        r.st.esc_cnt = 2'd2;
                    else
                    begin
                        row = (ts == 2'd3) ? 2'd2 : ts;
                        r.v = 1'b1;
                        ch  = alpha_char(row, c - 5'd6, version_reg == 4'd1);
                    end
                    r.st.temp_shift = 2'd0;
                end
            endcase
        end
        // carriage return maps to the newline register
        if (r.kind == KIND_CHAR)
            r.value = {9'd0, (ch == CH_CR) ? newline_reg : ch};
        return r;
    endfunction

    // Handshakes
    assign pop     = results.valid && results.ready;
    assign load_ok = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && pop);
    assign load    = inv_reg && load_ok;
    assign words.ready = !inv_reg || load_ok;
    assign cfg.ready   = 1'b1;

    // Three codes, high first, chained through the bank state
    assign s0 = restart_reg ? '0 : bank_reg[abbr_reg];
    always_comb
    begin
        d0 = decode_code(s0,    word_reg[14:10], abbr_reg);
        d1 = decode_code(d0.st, word_reg[9:5],   abbr_reg);
        d2 = decode_code(d1.st, word_reg[4:0],   abbr_reg);
    end

    // Pack the produced results to the front
    assign n_res = {1'b0, d0.v} + {1'b0, d1.v} + {1'b0, d2.v};
    assign p0    = d0.v ? d0 : (d1.v ? d1 : d2);
    assign p1    = (d0.v && d1.v) ? d1 : d2;

    // Bank and buffer next state
    always_comb
    begin
        bank_next[0] = bank_reg[0];
        bank_next[1] = bank_reg[1];
        res_cnt_next = res_cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            res_kind_next[i]  = res_kind_reg[i];
            res_value_next[i] = res_value_reg[i];
            res_last_next[i]  = res_last_reg[i];
        end
        if (load)
        begin
            bank_next[abbr_reg] = d2.st;
            res_cnt_next        = n_res;
            res_kind_next[0]    = p0.kind;
            res_value_next[0]   = p0.value;
            res_kind_next[1]    = p1.kind;
            res_value_next[1]   = p1.value;
            res_kind_next[2]    = d2.kind;
            res_value_next[2]   = d2.value;
            res_last_next[0]    = (n_res == 2'd1);
            res_last_next[1]    = (n_res == 2'd2);
            res_last_next[2]    = (n_res == 2'd3);
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            for (int i = 0; i < 2; i++)
            begin
                res_kind_next[i]  = res_kind_reg[i+1];
                res_value_next[i] = res_value_reg[i+1];
                res_last_next[i]  = res_last_reg[i+1];
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= 1'b0;
            res_cnt_reg   <= 2'd0;
            bank_reg[0]   <= '0;
            bank_reg[1]   <= '0;
            version_reg   <= VERSION_RST;
            abbr_base_reg <= ABBR_BASE_RST;
            newline_reg   <= NEWLINE_RST;
        end
        else
        begin
            if (words.ready)
                inv_reg <= words.valid;
            res_cnt_reg <= res_cnt_next;
            bank_reg[0] <= bank_next[0];
            bank_reg[1] <= bank_next[1];
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_VERSION:   version_reg   <= cfg.data[VER_W-1:0];
                    CFG_ABBR_BASE: abbr_base_reg <= cfg.data[BASE_W-1:0];
                    CFG_NEWLINE:   newline_reg   <= cfg.data[CHAR_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (words.valid && words.ready)
        begin
            word_reg    <= words.word;
            restart_reg <= words.restart;
            abbr_reg    <= words.in_abbreviation;
        end
        for (int i = 0; i < 3; i++)
        begin
            res_kind_reg[i]  <= res_kind_next[i];
            res_value_reg[i] <= res_value_next[i];
            res_last_reg[i]  <= res_last_next[i];
        end
    end

    // Result channel
    assign results.valid = (res_cnt_reg != 2'd0);
    assign results.kind  = res_kind_reg[0];
    assign results.value = res_value_reg[0];
    assign results.last  = res_last_reg[0];

`ifndef NO_ASSERTIONS
    // a head beat without last must have a follower queued
    a_last_follow: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.last |-> res_cnt_reg >= 2'd2)
        else $error("result without last has no follower");

    // a load that produced results presents a beat next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && n_res != 2'd0 |=> results.valid)
        else $error("loaded results not presented");

    // escape count only ever counts down from two
    a_esc_range: assert property (@(posedge clk) disable iff (!rst_n)
        bank_reg[0].esc_cnt != 2'd3 && bank_reg[1].esc_cnt != 2'd3)
        else $error("escape count out of range");
`endif

endmodule
